// ===== rtl/mdq_pkg.sv =====
// mdq_pkg: shared types and constants for the mouse delta to quadrature core
// no dependencies; imported by the axis lane, the line merge and the top level

package mdq_pkg;

  // action codes of an input item
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // step count saturation and accumulator phase byte position
  localparam logic [7:0] COUNT_MAX   = 8'hff;
  localparam int         PHASE_SHIFT = 8;

  // line vector layout: quadrature lines from bit0, buttons above
  localparam int LINE_W   = 6;
  localparam int X_A_BIT  = 0;
  localparam int X_B_BIT  = 1;
  localparam int Y_A_BIT  = 2;
  localparam int Y_B_BIT  = 3;
  localparam int BTN0_BIT = 4;
  localparam int BTN1_BIT = 5;

  // line levels after reset: quadrature low, both buttons released
  localparam logic [LINE_W-1:0] LINES_RESET = 6'b11_0000;

  // what one axis lane reports for an item
  typedef struct packed {
    logic       drive;  // lane moved its phase, lines below are valid
    logic [1:0] lines;  // bit0 line A, bit1 line B
  } lane_out_t;

endpackage

// ===== rtl/mouse_delta_to_quadrature_core.sv =====
// mouse_delta_to_quadrature_core: top level with two axis lanes, line merge and output buffer
// depends on mdq_pkg, mdq_axis and mdq_merge
//
// Takes timer ticks and mouse reports, one item per clock while in_stall is low, and returns
// for every item the levels of all six lines as they stand after it: two quadrature pairs and
// two active-low button lines. The x and y lanes update in the cycle an item is accepted and
// the result is registered in the output register, or in a skid register behind it while the
// output side stalls; the sustained rate is one item per cycle while the output side does not
// stall. The skid register keeps the input open for one more item while the output side
// stalls; the input stalls only once both hold an item.

module mouse_delta_to_quadrature_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [1:0]        in_buttons,
  input  logic signed [7:0] in_dx,
  input  logic signed [7:0] in_dy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_x_a,
  output logic              out_x_b,
  output logic              out_y_a,
  output logic              out_y_b,
  output logic              out_first_button_n,
  output logic              out_second_button_n
);
  import mdq_pkg::*;

  logic              in_acc;
  logic              is_report;
  lane_out_t         x_res;
  lane_out_t         y_res;
  logic [LINE_W-1:0] lines_nxt;
  logic [LINE_W-1:0] lines_cur;

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [LINE_W-1:0] out_data_r, out_data_nxt;
  logic [LINE_W-1:0] skid_data_r, skid_data_nxt;
  logic              out_take;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign is_report = (in_action == ACT_REPORT);

  // axis lanes
  mdq_axis u_x_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .is_report (is_report),
    .d         (in_dx),
    .res       (x_res)
  );

  mdq_axis u_y_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .is_report (is_report),
    .d         (in_dy),
    .res       (y_res)
  );

  // merge of lane results and button lines
  mdq_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .is_report (is_report),
    .buttons   (in_buttons),
    .x_res     (x_res),
    .y_res     (y_res),
    .lines_nxt (lines_nxt),
    .lines_cur (lines_cur)
  );

  // output register with skid stage
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = lines_nxt;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = lines_nxt;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // result ports
  assign out_valid           = out_valid_r;
  assign out_x_a             = out_data_r[X_A_BIT];
  assign out_x_b             = out_data_r[X_B_BIT];
  assign out_y_a             = out_data_r[Y_A_BIT];
  assign out_y_b             = out_data_r[Y_B_BIT];
  assign out_first_button_n  = out_data_r[BTN0_BIT];
  assign out_second_button_n = out_data_r[BTN1_BIT];

  // skid holds an item only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // a report never moves the quadrature lines
  a_report_keeps_quad: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_report) |-> (lines_nxt[Y_B_BIT:X_A_BIT] == lines_cur[Y_B_BIT:X_A_BIT]))
    else $error("report changed quadrature lines");

  // a tick never moves the button lines
  a_tick_keeps_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_report) |-> (lines_nxt[BTN1_BIT:BTN0_BIT] == lines_cur[BTN1_BIT:BTN0_BIT]))
    else $error("tick changed button lines");

  // an accepted item always reaches the output side on the next cycle
  a_item_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item lost");

endmodule

// ===== rtl/mdq_axis.sv =====
// mdq_axis: one axis lane with step count, signed rate, accumulator and phase
// depends on mdq_pkg

module mdq_axis (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              is_report,
  input  logic signed [7:0] d,
  output mdq_pkg::lane_out_t res
);
  import mdq_pkg::*;

  logic        [15:0] accum_r, accum_nxt;
  logic signed [15:0] rate_r, rate_nxt;
  logic        [7:0]  pending_r, pending_nxt;
  logic        [7:0]  phase_r, phase_nxt;

  logic        [8:0]  d_ext;
  logic        [8:0]  mag;
  logic        [8:0]  cnt_sum;
  logic signed [17:0] rate_sum;
  logic        [15:0] accum_sum;
  logic        [7:0]  hi;
  logic               moving;
  logic               phase_move;

  // report arithmetic: magnitude into the count, twice the move into the rate
  assign d_ext    = {d[7], d};
  assign mag      = d[7] ? 9'(-d_ext) : d_ext;
  assign cnt_sum  = {1'b0, pending_r} + mag;
  assign rate_sum = {{2{rate_r[15]}}, rate_r} + {{9{d[7]}}, d, 1'b0};

  // tick arithmetic: wrapping accumulator and its phase byte
  assign accum_sum  = accum_r + $unsigned(rate_r);
  assign hi         = accum_sum[PHASE_SHIFT +: 8];
  assign moving     = (pending_r != 8'd0);
  assign phase_move = moving && (hi != phase_r);

  // next state of the lane
  always_comb begin
    accum_nxt   = accum_r;
    rate_nxt    = rate_r;
    pending_nxt = pending_r;
    phase_nxt   = phase_r;
    if (step_en) begin
      if (is_report) begin
        pending_nxt = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[7:0];
        if (rate_sum > 18'sd32767) begin
          rate_nxt = 16'sh7fff;
        end else if (rate_sum < -18'sd32768) begin
          rate_nxt = -16'sh8000;
        end else begin
          rate_nxt = rate_sum[15:0];
        end
      end else if (!moving) begin
        rate_nxt = '0;
      end else begin
        accum_nxt = accum_sum;
        if (phase_move) begin
          phase_nxt   = hi;
          pending_nxt = pending_r - 8'd1;
        end
      end
    end
  end

  // lane state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r   <= '0;
      rate_r    <= '0;
      pending_r <= '0;
      phase_r   <= '0;
    end else begin
      accum_r   <= accum_nxt;
      rate_r    <= rate_nxt;
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // line pattern of the new phase: A = bit0 xor bit1, B = bit1
  assign res.drive = step_en && !is_report && phase_move;
  assign res.lines = {hi[1], hi[0] ^ hi[1]};

endmodule

// ===== rtl/mdq_merge.sv =====
// mdq_merge: holds the quadrature and button line levels and merges lane results
// depends on mdq_pkg

module mdq_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         is_report,
  input  logic [1:0]                   buttons,
  input  mdq_pkg::lane_out_t           x_res,
  input  mdq_pkg::lane_out_t           y_res,
  output logic [mdq_pkg::LINE_W-1:0]   lines_nxt,
  output logic [mdq_pkg::LINE_W-1:0]   lines_cur
);
  import mdq_pkg::*;

  logic [LINE_W-1:0] lines_r;

  // buttons follow a report, each axis pair follows its own lane on a tick
  always_comb begin
    lines_nxt = lines_r;
    if (step_en) begin
      if (is_report) begin
        lines_nxt[BTN0_BIT] = ~buttons[0];
        lines_nxt[BTN1_BIT] = ~buttons[1];
      end else begin
        if (x_res.drive) begin
          lines_nxt[X_A_BIT] = x_res.lines[0];
          lines_nxt[X_B_BIT] = x_res.lines[1];
        end
        if (y_res.drive) begin
          lines_nxt[Y_A_BIT] = y_res.lines[0];
          lines_nxt[Y_B_BIT] = y_res.lines[1];
        end
      end
    end
  end

  // line levels: quadrature low, buttons released after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= LINES_RESET;
    end else begin
      lines_r <= lines_nxt;
    end
  end

  assign lines_cur = lines_r;

endmodule

// ===== sim/mouse_delta_to_quadrature_core_test.sv =====
// mouse_delta_to_quadrature_core_test: self-checking bench for the mouse delta to quadrature core
// depends on mdq_pkg and mouse_delta_to_quadrature_core; a built-in line model predicts each item
`timescale 1ns / 100ps

module mouse_delta_to_quadrature_core_test;
  import mdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTS = 30;

  // clock, reset and block ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = ACT_TICK;
  logic [1:0]        in_buttons = 2'b00;
  logic signed [7:0] in_dx = 8'sd0;
  logic signed [7:0] in_dy = 8'sd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_x_a;
  logic              out_x_b;
  logic              out_y_a;
  logic              out_y_b;
  logic              out_first_button_n;
  logic              out_second_button_n;

  // line model: per axis accumulator, signed rate, pending steps and phase byte
  logic [15:0]        axis_acc   [2];
  logic signed [15:0] axis_rate  [2];
  logic [7:0]         axis_steps [2];
  logic [7:0]         axis_phase [2];
  logic [LINE_W-1:0]  line_levels;

  // expected line levels, oldest first
  logic [LINE_W-1:0] levels_due [$];

  string line_names [LINE_W] = '{"x_a", "x_b", "y_a", "y_b", "first_button_n",
                                 "second_button_n"};

  int mismatch_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  int send_gap_max = 0;
  int recv_stall_max = 0;
  int stall_left = 0;
  bit take_now = 1'b0;
  logic [LINE_W-1:0] seen_levels;
  logic [LINE_W-1:0] want_levels;

  mouse_delta_to_quadrature_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_buttons          (in_buttons),
    .in_dx               (in_dx),
    .in_dy               (in_dy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_x_a             (out_x_a),
    .out_x_b             (out_x_b),
    .out_y_a             (out_y_a),
    .out_y_b             (out_y_b),
    .out_first_button_n  (out_first_button_n),
    .out_second_button_n (out_second_button_n)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still due", cycle_count, levels_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic model_reset();
    for (int ax = 0; ax < 2; ax++) begin
      axis_acc[ax] = '0;
      axis_rate[ax] = '0;
      axis_steps[ax] = '0;
      axis_phase[ax] = '0;
    end
    line_levels = '0;
    line_levels[BTN0_BIT] = 1'b1;
    line_levels[BTN1_BIT] = 1'b1;
  endtask

  // one tick on one axis: advance accumulator while steps are pending, else drop the rate
  task automatic tick_axis(input int ax, output bit moved, output logic [1:0] pat);
    logic [7:0] hi;
    moved = 1'b0;
    pat = 2'b00;
    if (axis_steps[ax] == 8'd0) begin
      axis_rate[ax] = '0;
    end else begin
      axis_acc[ax] = axis_acc[ax] + axis_rate[ax];
      hi = 8'(axis_acc[ax] >> PHASE_SHIFT);
      if (hi != axis_phase[ax]) begin
        axis_phase[ax] = hi;
        axis_steps[ax] = axis_steps[ax] - 8'd1;
        moved = 1'b1;
        pat = {hi[1], hi[0] ^ hi[1]};
      end
    end
  endtask

  // report on one axis: saturating step count and saturating rate
  task automatic move_axis(input int ax, input logic signed [7:0] d);
    int dv;
    int mag;
    int sum;
    dv = d;
    mag = (dv < 0) ? -dv : dv;
    sum = axis_steps[ax] + mag;
    axis_steps[ax] = (sum > COUNT_MAX) ? COUNT_MAX : sum[7:0];
    sum = int'(axis_rate[ax]) + 2 * dv;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    axis_rate[ax] = sum[15:0];
  endtask

  // line levels after one item
  task automatic advance_lines(input logic act, input logic [1:0] btn,
                               input logic signed [7:0] dx, input logic signed [7:0] dy,
                               output logic [LINE_W-1:0] lv);
    bit moved;
    logic [1:0] pat;
    if (act == ACT_REPORT) begin
      line_levels[BTN0_BIT] = ~btn[0];
      line_levels[BTN1_BIT] = ~btn[1];
      move_axis(0, dx);
      move_axis(1, dy);
    end else begin
      tick_axis(0, moved, pat);
      if (moved) begin
        line_levels[X_A_BIT] = pat[0];
        line_levels[X_B_BIT] = pat[1];
      end
      tick_axis(1, moved, pat);
      if (moved) begin
        line_levels[Y_A_BIT] = pat[0];
        line_levels[Y_B_BIT] = pat[1];
      end
    end
    lv = line_levels;
  endtask

  // send one item; called at a rising edge, returns at the edge that accepts it
  task automatic push_item(input logic act, input logic [1:0] btn,
                           input logic signed [7:0] dx, input logic signed [7:0] dy);
    int gap;
    bit stalled;
    logic [LINE_W-1:0] lv;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_buttons <= btn;
    in_dx <= dx;
    in_dy <= dy;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    advance_lines(act, btn, dx, dy, lv);
    levels_due.push_back(lv);
  endtask

  // tick with junk in the fields that a tick ignores
  task automatic push_tick();
    push_item(ACT_TICK, 2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // sender goes idle until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [7:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($signed($urandom_range(0, 8)) - 4);
      8:          return 8'sd127;
      9:          return -8'sd128;
      default:    return 8'($urandom);
    endcase
  endfunction

  // result side: sample at the falling edge, the item moves at the next rising edge
  always @(negedge clk) begin
    take_now = rst_n && out_valid && !out_stall;
    if (take_now) begin
      result_count++;
      seen_levels[X_A_BIT] = out_x_a;
      seen_levels[X_B_BIT] = out_x_b;
      seen_levels[Y_A_BIT] = out_y_a;
      seen_levels[Y_B_BIT] = out_y_b;
      seen_levels[BTN0_BIT] = out_first_button_n;
      seen_levels[BTN1_BIT] = out_second_button_n;
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_count));
      end else begin
        want_levels = levels_due.pop_front();
        for (int i = 0; i < LINE_W; i++)
          if (seen_levels[i] !== want_levels[i])
            report_mismatch($sformatf("result %0d %s got %b expected %b", result_count,
                                      line_names[i], seen_levels[i], want_levels[i]));
      end
    end
  end

  // result side stall: a fresh wait drawn for every item taken
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
    end else if (take_now) begin
      stall_left = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // reset levels, every button pattern, delta extremes and ignored tick fields
  task automatic test_directed();
    push_tick();
    push_item(ACT_REPORT, 2'b01, 8'sd0, 8'sd0);
    push_item(ACT_REPORT, 2'b10, 8'sd1, -8'sd1);
    push_item(ACT_REPORT, 2'b11, 8'sd127, -8'sd128);
    push_item(ACT_REPORT, 2'b00, -8'sd128, 8'sd127);
    repeat (8) push_item(ACT_TICK, 2'b00, 8'sd0, 8'sd0);
    push_item(ACT_REPORT, 2'b11, -8'sd1, 8'sd0);
    push_item(ACT_TICK, 2'b11, -8'sd128, 8'sd127);
    push_item(ACT_TICK, 2'b10, 8'sd127, -8'sd128);
    repeat (4) push_item(ACT_TICK, 2'b01, 8'sd85, -8'sd86);
    push_item(ACT_REPORT, 2'b00, 8'sd0, 8'sd0);
    repeat (3) push_tick();
  endtask

  // saturate both step counts and drive rates to both limits, draining the steps in between
  task automatic test_rate_limits();
    repeat (132) push_item(ACT_REPORT, 2'($urandom), 8'sd127, -8'sd128);
    repeat (260) push_tick();
    repeat (130) push_item(ACT_REPORT, 2'($urandom), -8'sd128, 8'sd127);
    repeat (40) push_tick();
  endtask

  // sender holds off until every result is back
  task automatic test_pause_until_drained();
    push_item(ACT_REPORT, 2'($urandom), pick_delta(), pick_delta());
    wait_drained();
    repeat (6) push_tick();
    wait_drained();
  endtask

  // mostly a report followed by a run of ticks, the rest single random items
  task automatic test_random_motion(input int n_items, input int gap_max, input int stall_max);
    int sent;
    int run;
    send_gap_max = gap_max;
    recv_stall_max = stall_max;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        push_item(ACT_REPORT, 2'($urandom), pick_delta(), pick_delta());
        run = $urandom_range(1, 24);
        repeat (run) push_tick();
        sent += run + 1;
      end else begin
        push_item(1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_gap_max = 14;
    recv_stall_max = 14;
    test_rate_limits();
    test_pause_until_drained();
    test_random_motion(150, 0, 0);
    test_random_motion(150, 14, 0);
    test_random_motion(150, 0, 14);
    test_random_motion(150, 14, 14);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && levels_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
